// ----- sv/pws_pkg.sv -----
// ----------------------------------------------------------------------------
// pws_pkg: shared types and constants
// Payload structs, operation codes and the back-end state enum.
// ----------------------------------------------------------------------------
package pws_pkg;

	localparam logic [31:0] STEP_RESET = 32'd10000000;

	typedef enum logic [2:0] {
		OP_ENQ   = 3'd0,
		OP_DEQ   = 3'd1,
		OP_YIELD = 3'd2,
		OP_PICK  = 3'd3,
		OP_TICK  = 3'd4
	} op_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [3:0]  task_slot;
		logic [31:0] task_period;
		logic        is_new;
		logic [63:0] now_time;
	} req_t;

	typedef struct packed {
		logic        status;
		logic        picked_valid;
		logic [3:0]  picked_task;
		logic [4:0]  queued_count;
		logic [63:0] second_wakeup;
	} rsp_t;

	// Classified command handed from front to back.
	typedef struct packed {
		req_t req;
		logic valid_op;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHARGE,
		ST_EXEC,
		ST_DIV,
		ST_MUL,
		ST_SCAN1,
		ST_SCAN2,
		ST_DONE
	} state_t;

endpackage

// ----- sv/pws_front.sv -----
// ----------------------------------------------------------------------------
// pws_front: input stage and command queue
// Accepts requests, classifies the mode and buffers two commands.
// ----------------------------------------------------------------------------
module pws_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  pws_pkg::req_t in_data,
	output logic          cmd_valid,
	output pws_pkg::cmd_t cmd,
	input  logic          cmd_take
);
	import pws_pkg::*;

	cmd_t        mem_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = mem_q[rd_q];

	// Store classified command
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q].req      <= in_data;
			mem_q[wr_q].valid_op <= (in_data.mode <= OP_TICK);
		end
	end

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full)
				wr_q <= ~wr_q;
			if (cmd_take && cmd_valid)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(cmd_take && cmd_valid);
		end
	end

endmodule

// ----- sv/pws_back.sv -----
// ----------------------------------------------------------------------------
// pws_back: task table engine
// Charges, executes the operation with an iterative divider, scans order.
// ----------------------------------------------------------------------------
module pws_back #(
	parameter int TASK_SLOTS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  pws_pkg::cmd_t cmd,
	output logic          cmd_take,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_data,
	output logic          rsp_valid,
	output pws_pkg::rsp_t rsp,
	input  logic          rsp_take
);
	import pws_pkg::*;

	localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CW = $clog2(TASK_SLOTS + 1);

	state_t      st_q, st_d;
	logic [31:0] step_q;
	logic [TASK_SLOTS-1:0] qf_q, yf_q;
	logic [63:0] wk_q [TASK_SLOTS];
	logic [31:0] per_q [TASK_SLOTS];
	logic [63:0] rt_q [TASK_SLOTS];
	logic [63:0] srt_q [TASK_SLOTS];
	logic [31:0] stp_q [TASK_SLOTS];
	logic [31:0] stamp_q;
	logic        run_v_q;
	logic [SW-1:0] run_s_q;
	logic [63:0] exec_q;

	req_t        r_q;
	logic        ok_q;
	logic [SW-1:0] tgt_q;
	logic        status_q, pv_q;
	logic [3:0]  pt_q;
	// divider and multiplier
	logic [63:0] num_q, quo_q, rem_q;
	logic [6:0]  it_q;
	logic [63:0] prod_q;
	logic [1:0]  mph_q;
	// scan
	logic [SW:0] idx_q;
	logic        bv_q;
	logic [SW-1:0] best_q, first_q;
	logic        fv_q;
	logic [CW-1:0] count_q;
	logic [63:0] sw_q;

	logic        slot_ok;
	logic [SW-1:0] slot;
	logic [SW-1:0] cur;
	logic        precedes;
	logic        scan_hit;
	logic        scan_last;
	logic [64:0] rem_sh;
	logic [63:0] delta;

	assign slot_ok = ({28'd0, r_q.task_slot} < 32'(TASK_SLOTS));
	assign slot    = SW'(r_q.task_slot);
	assign cur     = idx_q[SW-1:0];
	assign delta   = r_q.now_time - exec_q;
	assign rem_sh  = {rem_q, num_q[63]};

	// Order compare of scanned slot against current best
	always_comb begin
		if (wk_q[cur] != wk_q[best_q])
			precedes = wk_q[cur][63:0] - wk_q[best_q] >= 64'h8000000000000000;
		else
			precedes = (stp_q[cur] - stp_q[best_q]) >= 32'h80000000;
	end

	// Scanned slot becomes the new candidate
	assign scan_hit  = qf_q[cur] && !(st_q == ST_SCAN2 && fv_q && cur == first_q)
	                   && (!bv_q || precedes);
	assign scan_last = (idx_q == (SW+1)'(TASK_SLOTS - 1));

	assign cmd_take  = (st_q == ST_IDLE) && cmd_valid;
	assign rsp_valid = (st_q == ST_DONE);
	assign rsp.status        = status_q;
	assign rsp.picked_valid  = pv_q;
	assign rsp.picked_task   = pt_q;
	assign rsp.queued_count  = 5'(count_q);
	assign rsp.second_wakeup = sw_q;

	// Next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:   if (cmd_valid) st_d = ST_CHARGE;
			ST_CHARGE: st_d = ok_q ? ST_EXEC : ST_SCAN1;
			ST_EXEC: begin
				st_d = ST_SCAN1;
				if (r_q.mode == OP_ENQ && slot_ok && !qf_q[slot] && !r_q.is_new
				    && (wk_q[slot] - r_q.now_time >= 64'h8000000000000000)
				    && r_q.task_period != 32'd0)
					st_d = ST_DIV;
				if (r_q.mode == OP_YIELD && run_v_q && per_q[run_s_q] != 32'd0)
					st_d = ST_DIV;
			end
			ST_DIV:    if (it_q == 7'd63) st_d = ST_MUL;
			ST_MUL:    if (mph_q == 2'd3) st_d = ST_SCAN1;
			ST_SCAN1:  if (scan_last) st_d = ST_SCAN2;
			ST_SCAN2:  if (scan_last) st_d = ST_DONE;
			ST_DONE:   if (rsp_take) st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	// Hold the state and the control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			step_q  <= STEP_RESET;
			qf_q    <= '0;
			yf_q    <= '0;
			stamp_q <= '0;
			run_v_q <= 1'b0;
			run_s_q <= '0;
			exec_q  <= '0;
			for (int i = 0; i < TASK_SLOTS; i++) begin
				wk_q[i]  <= '0;
				per_q[i] <= '0;
				rt_q[i]  <= '0;
				srt_q[i] <= '0;
				stp_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			if (cfg_we)
				step_q <= cfg_data;
			case (st_q)
				ST_CHARGE: begin
					if (ok_q && run_v_q && qf_q[run_s_q] && delta != 64'd0
					    && !delta[63]) begin
						rt_q[run_s_q] <= rt_q[run_s_q] + delta;
						exec_q <= r_q.now_time;
					end
				end
				ST_EXEC: begin
					case (r_q.mode)
						OP_ENQ: if (slot_ok && !qf_q[slot]) begin
							per_q[slot] <= r_q.task_period;
							qf_q[slot]  <= 1'b1;
							stp_q[slot] <= stamp_q;
							stamp_q     <= stamp_q + 32'd1;
							if (r_q.is_new) begin
								wk_q[slot]  <= r_q.now_time + 64'(r_q.task_period);
								rt_q[slot]  <= '0;
								srt_q[slot] <= '0;
							end else if (wk_q[slot] - r_q.now_time
							             >= 64'h8000000000000000) begin
								rt_q[slot] <= '0;
								if (r_q.task_period == 32'd0)
									wk_q[slot] <= r_q.now_time + 64'(step_q);
							end
						end
						OP_DEQ: if (slot_ok && qf_q[slot])
							qf_q[slot] <= 1'b0;
						OP_YIELD: if (run_v_q) begin
							if (rt_q[run_s_q] != 64'd0) begin
								srt_q[run_s_q] <= rt_q[run_s_q];
								yf_q[run_s_q]  <= 1'b1;
								rt_q[run_s_q]  <= '0;
							end
							if (per_q[run_s_q] == 32'd0)
								wk_q[run_s_q] <= r_q.now_time + 64'(step_q);
							qf_q[run_s_q]  <= 1'b1;
							stp_q[run_s_q] <= stamp_q;
							stamp_q        <= stamp_q + 32'd1;
						end
						default: ;
					endcase
				end
				ST_MUL: if (mph_q == 2'd3)
					wk_q[tgt_q] <= wk_q[tgt_q] + prod_q;
				ST_SCAN2: if (scan_last && r_q.mode == OP_PICK
				              && ok_q && fv_q && wk_q[first_q] <= r_q.now_time) begin
					run_v_q <= 1'b1;
					run_s_q <= first_q;
					exec_q  <= r_q.now_time;
				end
				default: ;
			endcase
		end
	end

	// Datapath: latch command, divide, multiply, scan
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				r_q  <= cmd.req;
				ok_q <= cmd.valid_op;
			end
			ST_CHARGE: begin
				status_q <= ~ok_q;
				pv_q     <= 1'b0;
				pt_q     <= '0;
				idx_q    <= '0;
				bv_q     <= 1'b0;
				count_q  <= '0;
			end
			ST_EXEC: begin
				case (r_q.mode)
					OP_ENQ: status_q <= ~(slot_ok && !qf_q[slot]);
					OP_DEQ: status_q <= ~(slot_ok && qf_q[slot]);
					OP_YIELD: status_q <= ~run_v_q;
					default: ;
				endcase
				tgt_q <= (r_q.mode == OP_YIELD) ? run_s_q : slot;
				num_q <= r_q.now_time - ((r_q.mode == OP_YIELD) ? wk_q[run_s_q] : wk_q[slot]);
				rem_q <= '0;
				it_q  <= '0;
				mph_q <= '0;
			end
			ST_DIV: begin
				// One restoring division bit per cycle
				it_q  <= it_q + 7'd1;
				num_q <= {num_q[62:0], 1'b0};
				if (rem_sh >= {33'd0, per_q[tgt_q]}) begin
					rem_q <= 64'(rem_sh - {33'd0, per_q[tgt_q]});
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh[63:0];
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end
			ST_MUL: begin
				// (q+1)*p from two 32x32 partial products
				mph_q <= mph_q + 2'd1;
				case (mph_q)
					2'd0: quo_q <= quo_q + 64'd1;
					2'd1: prod_q <= {32'd0, quo_q[31:0]} * {32'd0, per_q[tgt_q]};
					2'd2: prod_q <= prod_q + {quo_q[63:32] * per_q[tgt_q], 32'd0};
					default: ;
				endcase
			end
			ST_SCAN1, ST_SCAN2: begin
				if (st_q == ST_SCAN1 && qf_q[cur])
					count_q <= count_q + CW'(1);
				if (scan_last) begin
					idx_q <= '0;
					bv_q  <= 1'b0;
					if (st_q == ST_SCAN1) begin
						fv_q    <= bv_q || qf_q[cur];
						first_q <= scan_hit ? cur : best_q;
					end else begin
						if (scan_hit)
							sw_q <= wk_q[cur];
						else if (bv_q)
							sw_q <= wk_q[best_q];
						else
							sw_q <= '0;
						if (r_q.mode == OP_PICK && ok_q && fv_q
						    && wk_q[first_q] <= r_q.now_time) begin
							pv_q <= 1'b1;
							pt_q <= 4'(first_q);
						end
					end
				end else begin
					idx_q <= idx_q + (SW+1)'(1);
					if (scan_hit) begin
						bv_q   <= 1'b1;
						best_q <= cur;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- sv/periodic_wakeup_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// periodic_wakeup_scheduler_unit: periodic task wakeup scheduler
// Keeps task slots ordered by wakeup time and serves scheduler operations.
// ----------------------------------------------------------------------------
// Usage:
//  Requests enter through push/full; each carries a mode, a slot, a period,
//  a fresh flag and the current time. Results leave through empty/pop, one
//  per request, in request order. zero_period_step is written by cfg_we and
//  cfg_data; the user must do so only while the block is idle, since the
//  block itself does not enforce it. A two-entry command queue sits in
//  front of the table engine, so requests are taken while the engine is
//  busy or a result waits to be popped. Each request passes a charge step,
//  an execute step if valid and two ordering scans over the slots; when a
//  wakeup is moved by whole periods it also passes the divider (one quotient
//  bit per cycle over 64 bits), then a split 64x32 multiply.
//  Reset clears the queue, the table, the running task and sets the step to
//  its default. While pop stays low the result is held, the engine stops,
//  and full rises once the command queue is filled.
module periodic_wakeup_scheduler_unit #(
	parameter int TASK_SLOTS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  pws_pkg::req_t in_data,
	output logic          empty,
	input  logic          pop,
	output pws_pkg::rsp_t out_data,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_data
);
	import pws_pkg::*;

	logic cmd_valid, cmd_take, rsp_valid;
	cmd_t cmd;

	assign empty = ~rsp_valid;

	pws_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_data(in_data),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
	);

	pws_back #(.TASK_SLOTS(TASK_SLOTS)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_take(cmd_take), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.rsp_valid(rsp_valid), .rsp(out_data), .rsp_take(pop)
	);

endmodule

// ----- sim/periodic_wakeup_scheduler_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_wakeup_scheduler_unit_tb: self-checking bench for the scheduler
// Drives scheduler operations through the request queue, predicts every
// result with a behavioral copy of the slot table and compares each popped
// transaction field by field. Random bursts, receiver stalls, one long hold
// that fills the input side, and several step register settings.
// ----------------------------------------------------------------------------
import pws_pkg::*;

class sched_scoreboard;
	localparam int NSLOT = 16;
	bit [31:0] step;
	bit        queued [NSLOT];
	bit [63:0] wake [NSLOT];
	bit [31:0] period [NSLOT];
	bit [63:0] run [NSLOT];
	bit [63:0] saved_run [NSLOT];
	bit        yielded [NSLOT];
	bit [31:0] stamp [NSLOT];
	bit [31:0] stamp_ctr;
	bit        run_valid;
	int        run_slot;
	bit [63:0] run_since;
	rsp_t      pending [$];
	int        errors;
	int        checked;

	function new();
		step = STEP_RESET;
		stamp_ctr = 0;
		run_valid = 0;
		run_slot = 0;
		run_since = 0;
		errors = 0;
		checked = 0;
		for (int i = 0; i < NSLOT; i++) begin
			queued[i] = 0; wake[i] = 0; period[i] = 0; run[i] = 0;
			saved_run[i] = 0; yielded[i] = 0; stamp[i] = 0;
		end
	endfunction

	function bit earlier(bit [63:0] a, bit [63:0] b);
		bit [63:0] d;
		d = a - b;
		return d[63];
	endfunction

	function bit ahead_of(int x, int y);
		bit [31:0] d;
		if (wake[x] != wake[y])
			return earlier(wake[x], wake[y]);
		d = stamp[x] - stamp[y];
		return d[31];
	endfunction

	function int earliest(int skip);
		int best;
		best = -1;
		for (int i = 0; i < NSLOT; i++) begin
			if (!queued[i] || i == skip)
				continue;
			if (best < 0 || ahead_of(i, best))
				best = i;
		end
		return best;
	endfunction

	function void place(int s, bit fresh, bit [63:0] now);
		bit [63:0] p;
		p = period[s];
		if (fresh) begin
			wake[s] = now + p;
			run[s] = 0;
			saved_run[s] = 0;
		end else if (earlier(wake[s], now)) begin
			if (p == 0)
				wake[s] = now + 64'(step);
			else
				wake[s] = wake[s] + (64'd1 + (now - wake[s]) / p) * p;
			run[s] = 0;
		end
		queued[s] = 1;
		stamp[s] = stamp_ctr;
		stamp_ctr++;
	endfunction

	// Note an accepted request: advance the table, queue its result.
	function void note_request(req_t r);
		rsp_t      o;
		bit [63:0] d;
		bit [63:0] p;
		int        f;
		int        s;
		int        n;
		o = '0;
		if (r.mode <= OP_TICK && run_valid && queued[run_slot]) begin
			d = r.now_time - run_since;
			if (d != 0 && !d[63]) begin
				run[run_slot] += d;
				run_since = r.now_time;
			end
		end
		case (r.mode)
			OP_ENQ: begin
				if (queued[r.task_slot]) o.status = 1;
				else begin
					period[r.task_slot] = r.task_period;
					place(r.task_slot, r.is_new, r.now_time);
				end
			end
			OP_DEQ: begin
				if (!queued[r.task_slot]) o.status = 1;
				else queued[r.task_slot] = 0;
			end
			OP_YIELD: begin
				if (!run_valid) o.status = 1;
				else begin
					s = run_slot;
					p = period[s];
					if (run[s] > 0) begin
						saved_run[s] = run[s];
						yielded[s] = 1;
						run[s] = 0;
					end
					if (p > 0)
						wake[s] = wake[s] + ((r.now_time - wake[s]) / p + 64'd1) * p;
					else
						wake[s] = r.now_time + 64'(step);
					queued[s] = 0;
					place(s, 0, r.now_time);
				end
			end
			OP_PICK: begin
				f = earliest(-1);
				if (f >= 0 && wake[f] <= r.now_time) begin
					o.picked_valid = 1;
					o.picked_task = f[3:0];
					run_valid = 1;
					run_slot = f;
					run_since = r.now_time;
				end
			end
			OP_TICK: ;
			default: o.status = 1;
		endcase
		n = 0;
		for (int i = 0; i < NSLOT; i++)
			if (queued[i]) n++;
		o.queued_count = n[4:0];
		if (n >= 2) begin
			f = earliest(-1);
			s = earliest(f);
			if (s >= 0) o.second_wakeup = wake[s];
		end
		pending.push_back(o);
	endfunction

	// Compare one popped transaction with the oldest prediction.
	function void check_result(rsp_t a);
		rsp_t e;
		if (pending.size() == 0) begin
			$error("unexpected result %p", a);
			errors++;
			return;
		end
		e = pending.pop_front();
		checked++;
		if (a.status !== e.status) begin
			$error("status: expected %0d actual %0d", e.status, a.status); errors++;
		end
		if (a.picked_valid !== e.picked_valid) begin
			$error("picked_valid: expected %0d actual %0d", e.picked_valid, a.picked_valid);
			errors++;
		end
		if (a.picked_task !== e.picked_task) begin
			$error("picked_task: expected %0d actual %0d", e.picked_task, a.picked_task);
			errors++;
		end
		if (a.queued_count !== e.queued_count) begin
			$error("queued_count: expected %0d actual %0d", e.queued_count, a.queued_count);
			errors++;
		end
		if (a.second_wakeup !== e.second_wakeup) begin
			$error("second_wakeup: expected %0h actual %0h", e.second_wakeup,
				a.second_wakeup);
			errors++;
		end
	endfunction
endclass

module periodic_wakeup_scheduler_unit_tb;
	logic  clk;
	logic  arst_n;
	logic  push;
	logic  full;
	req_t  in_data;
	logic  empty;
	logic  pop;
	rsp_t  out_data;
	logic  cfg_we;
	logic  [31:0] cfg_data;

	sched_scoreboard board;
	bit        hold_rx;
	bit        drain_stall;
	bit [63:0] clock_now;
	int        sent;
	int        ops_seen [8];

	periodic_wakeup_scheduler_unit uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_data(in_data),
		.empty(empty), .pop(pop), .out_data(out_data), .cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("periodic_wakeup_scheduler_unit: mismatch");
		$finish;
	end

	// Offer one request and hold it until the block takes it; push stays up.
	task automatic send(req_t r);
		push <= 1;
		in_data <= r;
		do @(posedge clk); while (full);
		board.note_request(r);
		ops_seen[r.mode]++;
		sent++;
		@(negedge clk);
	endtask

	task automatic send_op(op_t m, int s, bit [31:0] p, bit fr, bit [63:0] t);
		req_t r;
		r.mode = m;
		r.task_slot = s[3:0];
		r.task_period = p;
		r.is_new = fr;
		r.now_time = t;
		send(r);
	endtask

	// Drop push, wait for every prediction to drain, then let the engine settle.
	task automatic drain();
		push <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_step(bit [31:0] v);
		cfg_we <= 1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
		board.step = v;
	endtask

	function automatic req_t rand_request();
		req_t r;
		int   k;
		k = $urandom_range(0, 99);
		r.task_slot = $urandom_range(0, 15);
		r.is_new = $urandom_range(0, 1);
		case ($urandom_range(0, 3))
			0: r.task_period = $urandom_range(0, 3);
			1: r.task_period = $urandom_range(0, 5000);
			2: r.task_period = $urandom;
			default: r.task_period = 32'hFFFF_FFF0 | $urandom_range(0, 15);
		endcase
		if (k < 30) r.mode = OP_ENQ;
		else if (k < 42) r.mode = OP_DEQ;
		else if (k < 58) r.mode = OP_YIELD;
		else if (k < 85) r.mode = OP_PICK;
		else if (k < 95) r.mode = OP_TICK;
		else r.mode = 3'($urandom_range(5, 7));
		// Mostly advance time; sometimes jump far, rarely go backwards.
		case ($urandom_range(0, 19))
			0: clock_now = {$urandom, $urandom};
			1: clock_now = clock_now - $urandom_range(1, 1000);
			2: clock_now = clock_now + ({$urandom, $urandom} >> 2);
			default: clock_now = clock_now + $urandom_range(0, 3000);
		endcase
		r.now_time = clock_now;
		return r;
	endfunction

	task automatic random_phase(int count);
		int left;
		int burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && left > 0) begin
				send(rand_request());
				burst--;
				left--;
			end
			if ($urandom_range(0, 2) != 0) begin
				push <= 0;
				repeat ($urandom_range(1, 40)) @(negedge clk);
			end
		end
	endtask

	// Receiver: pop on its own stall pattern, or hold off on request.
	initial begin
		pop = 0;
		forever begin
			@(negedge clk);
			if (hold_rx) pop <= 0;
			else if (drain_stall) pop <= ($urandom_range(0, 3) != 0);
			else pop <= 1;
		end
	end

	always @(posedge clk)
		if (arst_n && pop && !empty) board.check_result(out_data);

	// Alternate stall-heavy and stall-free stretches.
	initial begin
		drain_stall = 0;
		forever begin
			repeat ($urandom_range(50, 400)) @(negedge clk);
			drain_stall = ~drain_stall;
		end
	end

	initial begin
		bit [63:0] top;
		board = new();
		push = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_data = '0;
		hold_rx = 0;
		sent = 0;
		clock_now = 64'd1000;
		top = 64'hFFFF_FFFF_FFFF_FFFF;
		arst_n = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: ignores, fresh and late enqueues, zero period, wrap.
		send_op(OP_YIELD, 0, 0, 0, 64'd5);
		send_op(OP_DEQ, 3, 0, 0, 64'd5);
		send_op(OP_PICK, 0, 0, 0, 64'd5);
		send_op(OP_ENQ, 0, 32'd100, 1, 64'd10);
		send_op(OP_ENQ, 0, 32'd100, 1, 64'd10);
		send_op(OP_ENQ, 15, 32'hFFFF_FFFF, 1, 64'd10);
		send_op(OP_ENQ, 7, 0, 0, 64'd20);
		send_op(OP_ENQ, 8, 0, 1, 64'd110);
		send_op(OP_PICK, 0, 0, 0, 64'd200);
		send_op(OP_TICK, 0, 0, 0, 64'd250);
		send_op(OP_TICK, 0, 0, 0, 64'd240);
		send_op(OP_YIELD, 0, 0, 0, 64'd777);
		send_op(OP_PICK, 0, 0, 0, top);
		send_op(OP_YIELD, 0, 0, 0, top);
		send_op(OP_DEQ, 7, 0, 0, top);
		send_op(OP_ENQ, 7, 32'd3, 0, top);
		send_op(OP_DEQ, 8, 0, 0, 64'd0);
		send_op(OP_ENQ, 8, 32'd1, 1, top - 1);
		send(req_t'({3'd5, 4'd1, 32'd1, 1'b1, 64'd9}));
		send(req_t'({3'd7, 4'd15, 32'hFFFF_FFFF, 1'b0, top}));
		send_op(OP_PICK, 0, 0, 0, 64'h8000_0000_0000_0000);
		send_op(OP_TICK, 15, 32'hAAAA_5555, 1, 64'h5555_AAAA_5555_AAAA);
		drain();

		// Random phases across step settings, extremes included.
		write_step(32'd0);
		random_phase(220);
		drain();
		write_step(32'hFFFF_FFFF);
		random_phase(220);

		// Hold the receiver off so the input side backs up.
		hold_rx = 1;
		fork
			begin
				random_phase(20);
				push <= 0;
			end
			begin
				repeat (1500) @(negedge clk);
				hold_rx = 0;
			end
		join
		drain();
		write_step($urandom);
		random_phase(220);
		drain();
		write_step(32'd1);
		random_phase(200);
		drain();

		$display("covered %0d requests, %0d results checked", sent, board.checked);
		$display("ops enq %0d deq %0d yield %0d pick %0d tick %0d other %0d",
			ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3], ops_seen[4],
			ops_seen[5] + ops_seen[6] + ops_seen[7]);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("periodic_wakeup_scheduler_unit: match");
		else
			$display("periodic_wakeup_scheduler_unit: mismatch");
		$finish;
	end
endmodule
